[design/mec_pkg.sv]
package mec_pkg;

  // field widths
  localparam int C_W   = 32;
  localparam int CNT_W = 12;

  // default number of fraction bits of the point coordinates
  localparam int FRAC_BITS_DEF = 28;

  // iteration limit after reset
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = 12'd511;

  // order tag: the loop holds at most three items
  localparam int TAG_W = 2;

endpackage

[design/mec_point_if.sv]
interface mec_point_if import mec_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [C_W-1:0] c_real;
  logic signed [C_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

[design/mec_count_if.sv]
interface mec_count_if import mec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink   (input valid, input iteration_count, output ready);
endinterface

[design/mec_cfg_if.sv]
interface mec_cfg_if import mec_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] max_iterations;

  modport source (output valid, output max_iterations, input ready);
  modport sink   (input valid, input max_iterations, output ready);
endinterface

[design/mandelbrot_escape_count_core.sv]
// Mandelbrot escape-time counter.
// point_i : one item is a point c (c_real, c_imag), signed, FRAC_BITS fraction bits.
// count_o : one item per point, iteration_count = steps of z = z*z + c done
//           before |z|^2 reached 4, or max_iterations if it never did.
// cfg_i   : writes max_iterations (reset 511); always ready, write only when idle.
// Each iteration runs through a three-stage loop: multiply, shift/add/escape
// compare, limit check and feedback. Up to three points share the loop in
// interleaved slots; a new point enters whenever the slot coming round is free.
// Results leave in the order the points arrived: a finished point keeps
// circling, frozen, until it is the oldest one.
// When the receiver stalls, the output register holds its item and finished
// points keep circling; nothing is dropped, and new points wait for a free slot.
// Reset clears all slot valid bits and the output valid bit and sets the limit to 511.
module mandelbrot_escape_count_core import mec_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mec_point_if.sink        point_i,
  mec_count_if.source      count_o,
  mec_cfg_if.sink          cfg_i
);

  // z stays below 4 + |c| in magnitude while it iterates
  localparam int XW = (FRAC_BITS + 6 > 34) ? FRAC_BITS + 6 : 34;
  localparam int PW = 2 * XW;
  localparam logic signed [PW:0] FOUR = {{(PW-2){1'b0}}, 3'b100} << FRAC_BITS;

  typedef logic signed [XW-1:0] zval_t;
  typedef logic signed [PW-1:0] prod_t;

  // configuration
  logic [CNT_W-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_ITER_RESET;
    end else if (cfg_i.valid) begin
      max_q <= cfg_i.max_iterations;
    end
  end

  assign cfg_i.ready = 1'b1;

  // loop registers
  logic             s0_valid_q, s1_valid_q, s2_valid_q;
  logic             s0_done_q, s1_done_q, s2_done_q;
  logic [TAG_W-1:0] s0_tag_q, s1_tag_q, s2_tag_q;
  logic [CNT_W-1:0] s0_cnt_q, s1_cnt_q, s2_cnt_q;
  zval_t            s0_x_q, s0_y_q, s0_cx_q, s0_cy_q;
  zval_t            s1_cx_q, s1_cy_q, s2_cx_q, s2_cy_q;
  prod_t            s1_xx_q, s1_yy_q, s1_xy_q;
  logic             s2_esc_q;
  zval_t            s2_nx_q, s2_ny_q;

  logic [TAG_W-1:0] tag_q, head_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] out_cnt_q;

  // stage 1 arithmetic: floor shifts, escape compare, next z
  prod_t             xx_s, yy_s, xy_s, nx_full, ny_full;
  logic signed [PW:0] mag_sum;
  logic              esc_d;

  always_comb begin
    xx_s    = s1_xx_q >>> FRAC_BITS;
    yy_s    = s1_yy_q >>> FRAC_BITS;
    xy_s    = s1_xy_q >>> (FRAC_BITS - 1);
    mag_sum = {xx_s[PW-1], xx_s} + {yy_s[PW-1], yy_s};
    esc_d   = (mag_sum >= FOUR);
    nx_full = xx_s - yy_s + PW'(s1_cx_q);
    ny_full = xy_s + PW'(s1_cy_q);
  end

  // stage 2 decision: finish, leave in order, or go round again
  logic fin, leave, recirc, accept;

  assign fin    = s2_done_q | s2_esc_q | (s2_cnt_q >= max_q);
  assign leave  = s2_valid_q & fin & (s2_tag_q == head_q) & (!out_valid_q | count_o.ready);
  assign recirc = s2_valid_q & !leave;
  assign accept = point_i.valid & point_i.ready;

  assign point_i.ready = !recirc;

  // valid bits and order counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      tag_q       <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= recirc | accept;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      if (accept) begin
        tag_q <= tag_q + 1'b1;
      end
      if (leave) begin
        head_q      <= head_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (count_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload of the loop
  always_ff @(posedge clk_i) begin
    // feedback or new point into stage 0
    if (recirc) begin
      s0_x_q    <= s2_nx_q;
      s0_y_q    <= s2_ny_q;
      s0_cx_q   <= s2_cx_q;
      s0_cy_q   <= s2_cy_q;
      s0_cnt_q  <= fin ? s2_cnt_q : s2_cnt_q + 1'b1;
      s0_done_q <= fin;
      s0_tag_q  <= s2_tag_q;
    end else begin
      s0_x_q    <= XW'(point_i.c_real);
      s0_y_q    <= XW'(point_i.c_imag);
      s0_cx_q   <= XW'(point_i.c_real);
      s0_cy_q   <= XW'(point_i.c_imag);
      s0_cnt_q  <= '0;
      s0_done_q <= 1'b0;
      s0_tag_q  <= tag_q;
    end
    // stage 1: full-width products
    s1_xx_q   <= s0_x_q * s0_x_q;
    s1_yy_q   <= s0_y_q * s0_y_q;
    s1_xy_q   <= s0_x_q * s0_y_q;
    s1_cx_q   <= s0_cx_q;
    s1_cy_q   <= s0_cy_q;
    s1_cnt_q  <= s0_cnt_q;
    s1_done_q <= s0_done_q;
    s1_tag_q  <= s0_tag_q;
    // stage 2: escape flag and next z
    s2_esc_q  <= esc_d;
    s2_nx_q   <= nx_full[XW-1:0];
    s2_ny_q   <= ny_full[XW-1:0];
    s2_cx_q   <= s1_cx_q;
    s2_cy_q   <= s1_cy_q;
    s2_cnt_q  <= s1_cnt_q;
    s2_done_q <= s1_done_q;
    s2_tag_q  <= s1_tag_q;
    // output register
    if (leave) begin
      out_cnt_q <= s2_cnt_q;
    end
  end

  assign count_o.valid           = out_valid_q;
  assign count_o.iteration_count = out_cnt_q;

`ifndef SYNTHESIS
  // occupied slots match the points taken in but not yet handed out
  a_slots_match_tags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({s0_valid_q, s1_valid_q, s2_valid_q}) == int'(TAG_W'(tag_q - head_q)))
    else $error("loop occupancy disagrees with order tags");

  // a result never exceeds the limit
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cnt_q <= max_q))
    else $error("iteration count above limit");

  // a new point only takes a slot nobody circles in
  a_no_slot_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (s0_tag_q == $past(tag_q)) && s0_valid_q && !s0_done_q)
    else $error("new point collided with a circling one");
`endif

endmodule

[verif/mec_test_if.sv]
`timescale 1ns / 1ps
// Interfaces live in the design tree; nothing extra is needed for the bench.
// This file carries the shared point record used by the test top.
package mec_test_pkg;
  import mec_pkg::*;

  typedef struct packed {
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
  } point_t;
endpackage

[verif/mandelbrot_escape_count_core_test.sv]
`timescale 1ns / 1ps
module mandelbrot_escape_count_core_test;
  import mec_pkg::*;
  import mec_test_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint LIMIT_CYCLES = 64'd40_000_000;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   src_idle_pct;
  int   snk_idle_pct;
  longint cycles = 0;

  mec_point_if point_ch ();
  mec_count_if count_ch ();
  mec_cfg_if   cfg_ch ();

  mandelbrot_escape_count_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .point_i (point_ch.sink),
    .count_o (count_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  // mismatch reporting
  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // floor(a*b / 2^sh) clamped to 64 signed bits
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    logic signed [127:0] p;
    p = $signed(128'(a)) * $signed(128'(b));
    p = p >>> sh;
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(p);
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  // escape-time count of one point under a given limit
  function automatic logic [CNT_W-1:0] escape_count(input point_t p,
                                                     input logic [CNT_W-1:0] lim);
    longint cx, cy, x, y, xx, yy, nx, ny;
    int n;
    cx = longint'(p.c_real);
    cy = longint'(p.c_imag);
    x = cx;
    y = cy;
    n = 0;
    while (n < lim) begin
      xx = fx_mul(x, x, FRAC);
      yy = fx_mul(y, y, FRAC);
      if (fx_add(xx, yy) >= (longint'(4) <<< FRAC)) break;
      nx = fx_add((yy == 64'sh8000_0000_0000_0000) ?
                  fx_add(fx_add(xx, 64'sh7FFF_FFFF_FFFF_FFFF), 1) : fx_add(xx, -yy), cx);
      ny = fx_add(fx_mul(x, y, FRAC - 1), cy);
      x = nx;
      y = ny;
      n++;
    end
    return n[CNT_W-1:0];
  endfunction

  // in-order store of expected counts
  class count_board;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] pending[$];

    function new();
      limit = MAX_ITER_RESET;
    endfunction

    function void note_point(point_t p);
      pending.push_back(escape_count(p, limit));
    endfunction

    task check_count(logic [CNT_W-1:0] got);
      logic [CNT_W-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected count %0d", got));
      end else begin
        want = pending.pop_front();
        if (got !== want) report($sformatf("iteration_count %0d, want %0d", got, want));
      end
    endtask
  endclass

  count_board board = new();

  // clock and cycle limit
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall, check at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && count_ch.valid && count_ch.ready) board.check_count(count_ch.iteration_count);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) count_ch.ready <= 1'b0;
    else count_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // valid stays up after an item so a following item can go back to back;
  // idle cycles and drain() drop it
  task automatic send_point(input point_t p);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    point_ch.valid  <= 1'b1;
    point_ch.c_real <= p.c_real;
    point_ch.c_imag <= p.c_imag;
    @(posedge clk_i);
    while (!point_ch.ready) @(posedge clk_i);
    board.note_point(p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    point_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // only while idle
  task automatic write_limit(input logic [CNT_W-1:0] v);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.max_iterations <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    board.limit = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic point_t rand_point();
    point_t p;
    int r;
    r = $urandom_range(9);
    if (r < 7) begin
      // mostly inside |re| < 2, |im| < 1.5 to reach deep iteration counts
      p.c_real = $signed(32'($urandom_range(0, 32'h3FFF_FFFF))) - 32'sh2000_0000;
      p.c_imag = $signed(32'($urandom_range(0, 32'h2FFF_FFFF))) - 32'sh1800_0000;
    end else begin
      p.c_real = $urandom;
      p.c_imag = $urandom;
    end
    return p;
  endfunction

  function automatic point_t mk(input int re, input int im);
    point_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  initial begin
    point_t p;
    errors = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    rst_ni = 1'b0;
    point_ch.valid = 1'b0;
    point_ch.c_real = '0;
    point_ch.c_imag = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_iterations = MAX_ITER_RESET;
    count_ch.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, origin, escape at once, boundary, bulb points
    send_point(mk(0, 0));
    send_point(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_point(mk(32'h8000_0000, 32'h8000_0000));
    send_point(mk(32'h8000_0000, 0));
    send_point(mk(0, 32'h7FFF_FFFF));
    send_point(mk(-32'sh2000_0000, 0));
    send_point(mk(32'h0400_0000, 0));
    send_point(mk(-32'sh1000_0000, 0));
    send_point(mk(-32'sh0C00_0000, 32'sh0200_0000));
    send_point(mk(32'h0000_0001, -1));
    send_point(mk(32'h0600_0000, 32'h0A00_0000));
    drain();
    write_limit(12'd4095);
    send_point(mk(0, 0));
    send_point(mk(-32'sh1000_0000, 0));
    send_point(mk(-32'sh1D00_0000, 32'h0010_0000));
    drain();
    write_limit(12'd1);
    send_point(mk(0, 0));
    send_point(mk(32'h2000_0000, 0));
    drain();
    write_limit(12'd0);
    send_point(mk(0, 0));
    send_point(mk(32'h7FFF_FFFF, 0));
    drain();

    // random phases with different limits and idling
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 50 : 0;
      snk_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 31 : 0;
      for (int s = 0; s < 4; s++) begin
        write_limit((s == 0) ? 12'd4095 : (s == 1) ? 12'd1 : 12'($urandom_range(2, 300)));
        for (int i = 0; i < ((s == 0) ? 10 : 60); i++) begin
          p = rand_point();
          send_point(p);
          if (i == 20) drain();
        end
        drain();
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[files.f]
design/mec_pkg.sv
design/mec_point_if.sv
design/mec_count_if.sv
design/mec_cfg_if.sv
design/mandelbrot_escape_count_core.sv
verif/mec_test_if.sv
verif/mandelbrot_escape_count_core_test.sv
